// ===== design/mpq_pkg.sv =====
// Shared types, constants and command/status structs for the min priority queue.
`default_nettype none

package mpq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W = 32;
    localparam int OCC_W = 7;

    typedef logic [1:0] action_t;

    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_EXTRACT = 2'd1;
    localparam action_t ACT_FIND = 2'd2;

    localparam logic signed [KEY_W-1:0] EMPTY_KEY = -32'sd1;

    typedef struct packed {
        action_t action;
        logic signed [KEY_W-1:0] key_in;
    } item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_out;
        logic was_empty;
        logic dropped_full;
        logic [OCC_W-1:0] occupancy;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_FD_RD,
        ST_FD_DATA,
        ST_EX_RD,
        ST_EX_LAST,
        ST_EX_KEY,
        ST_DN_CHK,
        ST_DN_RL,
        ST_DN_RR,
        ST_DN_CMP,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        RD_ROOT,
        RD_LAST,
        RD_PARENT,
        RD_LEFT,
        RD_RIGHT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_KEY,
        WR_PARENT,
        WR_CHILD
    } wr_sel_t;

    typedef struct packed {
        logic capture;
        logic set_empty;
        logic set_full;
        logic start_ins;
        logic dec_count;
        logic take_result;
        logic take_key;
        logic take_child;
        logic pick_right;
        logic emit;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic pos_zero;
        logic left_in;
        logic right_in;
        logic parent_gt;
        logic child_lt;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/mpq_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/mpq_ctrl.sv =====
// Controller state machine that sequences insert, extract and find over the heap datapath.
`default_nettype none

module mpq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire mpq_pkg::action_t action,
    input  wire mpq_pkg::stat_t   stat,
    output logic                  item_stall,
    output mpq_pkg::cmd_t         cmd
);

    mpq_pkg::state_t state_reg;
    mpq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpq_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (action)
                        mpq_pkg::ACT_INSERT:
                            state_next = stat.count_full ? mpq_pkg::ST_FIN : mpq_pkg::ST_UP_CHK;
                        mpq_pkg::ACT_EXTRACT:
                            state_next = stat.count_zero ? mpq_pkg::ST_FIN : mpq_pkg::ST_EX_RD;
                        mpq_pkg::ACT_FIND:
                            state_next = stat.count_zero ? mpq_pkg::ST_FIN : mpq_pkg::ST_FD_RD;
                        default:
                            state_next = mpq_pkg::ST_FIN;
                    endcase
                end
            end
            mpq_pkg::ST_UP_CHK:
                state_next = stat.pos_zero ? mpq_pkg::ST_FIN : mpq_pkg::ST_UP_CMP;
            mpq_pkg::ST_UP_CMP:
                state_next = stat.parent_gt ? mpq_pkg::ST_UP_CHK : mpq_pkg::ST_FIN;
            mpq_pkg::ST_FD_RD:
                state_next = mpq_pkg::ST_FD_DATA;
            mpq_pkg::ST_FD_DATA:
                state_next = mpq_pkg::ST_FIN;
            mpq_pkg::ST_EX_RD:
                state_next = mpq_pkg::ST_EX_LAST;
            mpq_pkg::ST_EX_LAST:
                state_next = mpq_pkg::ST_EX_KEY;
            mpq_pkg::ST_EX_KEY:
                state_next = mpq_pkg::ST_DN_CHK;
            mpq_pkg::ST_DN_CHK:
                state_next = stat.left_in ? mpq_pkg::ST_DN_RL : mpq_pkg::ST_FIN;
            mpq_pkg::ST_DN_RL:
                state_next = stat.right_in ? mpq_pkg::ST_DN_RR : mpq_pkg::ST_DN_CMP;
            mpq_pkg::ST_DN_RR:
                state_next = mpq_pkg::ST_DN_CMP;
            mpq_pkg::ST_DN_CMP:
                state_next = stat.child_lt ? mpq_pkg::ST_DN_CHK : mpq_pkg::ST_FIN;
            mpq_pkg::ST_FIN:
                state_next = stat.out_free ? mpq_pkg::ST_IDLE : mpq_pkg::ST_FIN;
            default:
                state_next = mpq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.rd_sel = mpq_pkg::RD_ROOT;
        cmd.wr_sel = mpq_pkg::WR_NONE;
        case (state_reg)
            mpq_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    case (action)
                        mpq_pkg::ACT_INSERT:
                        begin
                            cmd.set_full = stat.count_full;
                            cmd.start_ins = !stat.count_full;
                        end
                        mpq_pkg::ACT_EXTRACT,
                        mpq_pkg::ACT_FIND:
                            cmd.set_empty = stat.count_zero;
                        default:
                            cmd.capture = 1'b1;
                    endcase
                end
            end
            mpq_pkg::ST_UP_CHK:
            begin
                if (stat.pos_zero)
                begin
                    cmd.wr_sel = mpq_pkg::WR_KEY;
                end
                else
                begin
                    cmd.rd_sel = mpq_pkg::RD_PARENT;
                end
            end
            mpq_pkg::ST_UP_CMP:
                cmd.wr_sel = stat.parent_gt ? mpq_pkg::WR_PARENT : mpq_pkg::WR_KEY;
            mpq_pkg::ST_FD_RD:
                cmd.rd_sel = mpq_pkg::RD_ROOT;
            mpq_pkg::ST_FD_DATA:
                cmd.take_result = 1'b1;
            mpq_pkg::ST_EX_RD:
            begin
                cmd.rd_sel = mpq_pkg::RD_ROOT;
                cmd.dec_count = 1'b1;
            end
            mpq_pkg::ST_EX_LAST:
            begin
                cmd.rd_sel = mpq_pkg::RD_LAST;
                cmd.take_result = 1'b1;
            end
            mpq_pkg::ST_EX_KEY:
                cmd.take_key = 1'b1;
            mpq_pkg::ST_DN_CHK:
            begin
                if (stat.left_in)
                begin
                    cmd.rd_sel = mpq_pkg::RD_LEFT;
                end
                else
                begin
                    cmd.wr_sel = mpq_pkg::WR_KEY;
                end
            end
            mpq_pkg::ST_DN_RL:
            begin
                cmd.take_child = 1'b1;
                if (stat.right_in)
                begin
                    cmd.rd_sel = mpq_pkg::RD_RIGHT;
                end
            end
            mpq_pkg::ST_DN_RR:
                cmd.pick_right = 1'b1;
            mpq_pkg::ST_DN_CMP:
                cmd.wr_sel = stat.child_lt ? mpq_pkg::WR_CHILD : mpq_pkg::WR_KEY;
            mpq_pkg::ST_FIN:
                cmd.emit = stat.out_free;
            default:
                cmd.emit = 1'b0;
        endcase
    end

    assign item_stall = (state_reg != mpq_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ===== design/mpq_dp.sv =====
// Heap datapath: key memory, index and key registers, comparators and the result register.
`default_nettype none

module mpq_dp #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mpq_pkg::item_t item,
    input  wire mpq_pkg::cmd_t  cmd,
    input  wire logic           result_stall,
    output mpq_pkg::stat_t      stat,
    output logic                result_valid,
    output mpq_pkg::result_t    result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NB_W = IDX_W + 2;
    localparam int KEY_BITS = mpq_pkg::KEY_W;
    localparam int OCC_BITS = mpq_pkg::OCC_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [IDX_W-1:0] cidx_reg;
    logic [IDX_W-1:0] cidx_next;
    logic signed [KEY_BITS-1:0] key_reg;
    logic signed [KEY_BITS-1:0] key_next;
    logic signed [KEY_BITS-1:0] child_reg;
    logic signed [KEY_BITS-1:0] child_next;
    logic signed [KEY_BITS-1:0] res_reg;
    logic signed [KEY_BITS-1:0] res_next;
    logic empty_reg;
    logic empty_next;
    logic full_reg;
    logic full_next;
    logic out_valid_reg;
    logic out_valid_next;
    mpq_pkg::result_t out_word_reg;
    mpq_pkg::result_t out_word_next;

    logic [IDX_W-1:0] parent_idx;
    logic [NB_W-1:0] left_idx;
    logic [NB_W-1:0] right_idx;
    logic [NB_W-1:0] count_ext;
    logic [IDX_W-1:0] rd_addr;
    logic [KEY_BITS-1:0] rd_data;
    logic signed [KEY_BITS-1:0] rd_key;
    logic wr_en;
    logic [KEY_BITS-1:0] wr_data;

    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign left_idx = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + NB_W'(1);
    assign count_ext = NB_W'(count_reg);
    assign rd_key = $signed(rd_data);

    always_comb
    begin
        case (cmd.rd_sel)
            mpq_pkg::RD_ROOT:   rd_addr = '0;
            mpq_pkg::RD_LAST:   rd_addr = count_reg[IDX_W-1:0];
            mpq_pkg::RD_PARENT: rd_addr = parent_idx;
            mpq_pkg::RD_LEFT:   rd_addr = left_idx[IDX_W-1:0];
            mpq_pkg::RD_RIGHT:  rd_addr = right_idx[IDX_W-1:0];
            default:            rd_addr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            mpq_pkg::WR_KEY:    wr_data = key_reg;
            mpq_pkg::WR_PARENT: wr_data = rd_data;
            mpq_pkg::WR_CHILD:  wr_data = child_reg;
            default:            wr_data = key_reg;
        endcase
    end

    assign wr_en = (cmd.wr_sel != mpq_pkg::WR_NONE);

    mpq_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(pos_reg),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        stat.count_zero = (count_reg == '0);
        stat.count_full = (count_reg == CNT_W'(CAPACITY));
        stat.pos_zero = (pos_reg == '0);
        stat.left_in = (left_idx < count_ext);
        stat.right_in = (right_idx < count_ext);
        stat.parent_gt = (rd_key > key_reg);
        stat.child_lt = (child_reg < key_reg);
        stat.out_free = !out_valid_reg || !result_stall;
    end

    always_comb
    begin
        count_next = count_reg;
        pos_next = pos_reg;
        cidx_next = cidx_reg;
        key_next = key_reg;
        child_next = child_reg;
        res_next = res_reg;
        empty_next = empty_reg;
        full_next = full_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_word_next = out_word_reg;
        if (cmd.capture)
        begin
            key_next = item.key_in;
            res_next = '0;
            empty_next = 1'b0;
            full_next = 1'b0;
        end
        if (cmd.set_empty)
        begin
            res_next = mpq_pkg::EMPTY_KEY;
            empty_next = 1'b1;
        end
        if (cmd.set_full)
        begin
            full_next = 1'b1;
        end
        if (cmd.start_ins)
        begin
            pos_next = count_reg[IDX_W-1:0];
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.dec_count)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.take_result)
        begin
            res_next = rd_key;
        end
        if (cmd.take_key)
        begin
            key_next = rd_key;
            pos_next = '0;
        end
        if (cmd.take_child)
        begin
            child_next = rd_key;
            cidx_next = left_idx[IDX_W-1:0];
        end
        if (cmd.pick_right && (rd_key < child_reg))
        begin
            child_next = rd_key;
            cidx_next = right_idx[IDX_W-1:0];
        end
        case (cmd.wr_sel)
            mpq_pkg::WR_PARENT: pos_next = parent_idx;
            mpq_pkg::WR_CHILD:  pos_next = cidx_reg;
            default:            pos_next = pos_next;
        endcase
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_word_next.key_out = res_reg;
            out_word_next.was_empty = empty_reg;
            out_word_next.dropped_full = full_reg;
            out_word_next.occupancy = OCC_BITS'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        cidx_reg <= cidx_next;
        key_reg <= key_next;
        child_reg <= child_next;
        res_reg <= res_next;
        empty_reg <= empty_next;
        full_reg <= full_next;
        out_word_reg <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result = out_word_reg;

endmodule

`default_nettype wire

// ===== design/min_priority_queue.sv =====
// Top level of the bounded min priority queue of signed 32-bit keys.
// The queue holds up to CAPACITY keys as a binary min-heap in one RAM and takes one word at a
// time. An insert climbs one level at a time, moving each greater parent down, then writes the
// key where it stops or at the root. An extract fetches the root and the last key, then
// descends, reading the left child and any right child and moving the smaller child up while
// it is less than the key, then writes the key where it stops or at a leaf. A find reads the
// root; an empty, refused or unused item goes straight to the result. Each heap level goes
// through the single registered read port of the key RAM. After the result is registered the
// controller returns to idle, where it takes the next word. The result word sits in an output
// register, so a new word is taken while the previous result still waits downstream; the
// following word waits in its final state for as long as that result stays stalled.
`default_nettype none

module min_priority_queue #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire mpq_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output mpq_pkg::result_t      result
);

    mpq_pkg::cmd_t cmd;
    mpq_pkg::stat_t stat;

    mpq_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .action(item.action),
        .stat(stat),
        .item_stall(item_stall),
        .cmd(cmd)
    );

    mpq_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .cmd(cmd),
        .result_stall(result_stall),
        .stat(stat),
        .result_valid(result_valid),
        .result(result)
    );

endmodule

`default_nettype wire

// ===== design/mpq_checker.sv =====
// Port-level checker for the min priority queue and its bind to the top level.
`default_nettype none

module mpq_checker #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire mpq_pkg::result_t result
);

    localparam int OCC_BITS = mpq_pkg::OCC_W;
    localparam logic [OCC_BITS-1:0] FULL_OCC = OCC_BITS'(CAPACITY);

    // A stalled result word holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

    // The queue works on one word at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
    else $error("second word taken while one is in progress");

    // An empty extract or find reports the empty key and an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.was_empty |->
            result.key_out == mpq_pkg::EMPTY_KEY && result.occupancy == '0 &&
            !result.dropped_full)
    else $error("empty result inconsistent");

    // A refused insert leaves the queue full and returns a zero key.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dropped_full |->
            result.key_out == '0 && result.occupancy == FULL_OCC)
    else $error("dropped insert inconsistent");

endmodule

bind min_priority_queue mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (.*);

`default_nettype wire
